// File: rtl/spqd_pkg.sv
// shared types and constants for the stable priority queue with duplicate refusal
// no dependencies; imported by spqd_ram users and the top level
`timescale 1ns / 1ps

package spqd_pkg;

    localparam int KEY_W = 34;
    localparam int LVL_W = 3;
    localparam int ST_W  = 3;

    // tdata carries key then level, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // result status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_SERVED    = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

    localparam logic [LVL_W-1:0] LVL_MIN = 3'd1;
    localparam logic [LVL_W-1:0] LVL_MAX = 3'd4;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [KEY_W-1:0] entry_key;
    } entry_t;

endpackage

// File: rtl/stable_priority_queue_dedup_core.sv
// top level of the stable priority queue with duplicate refusal
// depends on spqd_pkg and spqd_ram
// insert scans every waiting entry before it writes; serve scans them, then shifts the entries behind the served one
// throughput: one item at a time; the scan over the entry ram (one read a cycle) sets the rate
// a finished result sits in the output register while the next item is accepted
// reset clears occupancy and control state; the entry ram is not cleared and needs no pass
`timescale 1ns / 1ps

module stable_priority_queue_dedup_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spqd_pkg::S_TDATA_W-1:0]  s_tdata,  // entry_key[33:0], level[36:34]
    input  logic                            s_tuser,  // action[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spqd_pkg::M_TDATA_W-1:0]  m_tdata,  // served_key[33:0], served_level[36:34]
    output logic [spqd_pkg::ST_W-1:0]       m_tuser   // status[2:0]
);

    import spqd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             pend_reg, pend_next;
    logic             action_reg, action_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             dup_reg, dup_next;
    logic [AW-1:0]    pick_reg, pick_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [LVL_W-1:0] best_lvl_reg, best_lvl_next;
    logic [ST_W-1:0]  status_reg, status_next;

    logic             m_valid_reg, m_valid_next;
    logic [KEY_W-1:0] m_key_reg, m_key_next;
    logic [LVL_W-1:0] m_lvl_reg, m_lvl_next;
    logic [ST_W-1:0]  m_st_reg, m_st_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    logic [AW-1:0]    ram_raddr;

    logic [LVL_W-1:0] in_lvl;
    logic             s_fire;
    logic             more;

    spqd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign more     = (rd_idx_reg < occ_reg);
    assign ram_raddr = rd_idx_reg[AW-1:0];

    // out-of-range levels are clamped into 1..4
    always_comb begin
        in_lvl = s_tdata[KEY_W +: LVL_W];
        if (in_lvl < LVL_MIN) begin
            in_lvl = LVL_MIN;
        end else if (in_lvl > LVL_MAX) begin
            in_lvl = LVL_MAX;
        end
    end

    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        pend_next     = 1'b0;
        action_next   = action_reg;
        key_next      = key_reg;
        lvl_next      = lvl_reg;
        dup_next      = dup_reg;
        pick_next     = pick_reg;
        best_key_next = best_key_reg;
        best_lvl_next = best_lvl_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_key_next    = m_key_reg;
        m_lvl_next    = m_lvl_reg;
        m_st_next     = m_st_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '{level: lvl_reg, entry_key: key_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    action_next   = s_tuser;
                    key_next      = s_tdata[KEY_W-1:0];
                    lvl_next      = in_lvl;
                    dup_next      = 1'b0;
                    pick_next     = '0;
                    best_key_next = '0;
                    best_lvl_next = '0;
                    rd_idx_next   = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                // one read issued per cycle, compared when its data returns
                if (more) begin
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    pend_next    = 1'b1;
                end
                if (pend_reg) begin
                    if (ram_rdata.entry_key == key_reg) begin
                        dup_next = 1'b1;
                    end
                    if (ram_rdata.level > best_lvl_reg) begin
                        best_lvl_next = ram_rdata.level;
                        best_key_next = ram_rdata.entry_key;
                        pick_next     = cmp_idx_reg;
                    end
                end
                if (!more && !pend_reg) begin
                    if (!action_reg) begin
                        if (dup_reg) begin
                            status_next = ST_DUPLICATE;
                        end else if (occ_reg == CW'(QUEUE_DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            status_next = ST_INSERTED;
                            ram_we      = 1'b1;
                            ram_waddr   = occ_reg[AW-1:0];
                            occ_next    = occ_reg + CW'(1);
                        end
                        state_next = S_DONE;
                    end else if (occ_reg == '0) begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end else begin
                        status_next = ST_SERVED;
                        rd_idx_next = CW'(pick_reg) + CW'(1);
                        state_next  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // close the gap: entry j moves to j-1
                if (more) begin
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    pend_next    = 1'b1;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cmp_idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (!more && !pend_reg) begin
                    occ_next   = occ_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_st_next    = status_reg;
                    // key and level only go out with a served entry
                    if (status_reg == ST_SERVED) begin
                        m_key_next = best_key_reg;
                        m_lvl_next = best_lvl_reg;
                    end else begin
                        m_key_next = '0;
                        m_lvl_next = '0;
                    end
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        action_reg   <= action_next;
        key_reg      <= key_next;
        lvl_reg      <= lvl_next;
        dup_reg      <= dup_next;
        pick_reg     <= pick_next;
        best_key_reg <= best_key_next;
        best_lvl_reg <= best_lvl_next;
        status_reg   <= status_next;
        m_key_reg    <= m_key_next;
        m_lvl_reg    <= m_lvl_next;
        m_st_reg     <= m_st_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_st_reg;
    assign m_tdata  = {{(M_TDATA_W - KEY_W - LVL_W){1'b0}}, m_lvl_reg, m_key_reg};

endmodule

// File: rtl/spqd_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module spqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
